// File: sv/hlg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Huber loss and gradient block.
// Used by hlg_lane, hlg_merge and huber_loss_and_gradient; depends on nothing.

package hlg_pkg;

  localparam int LANES      = 4;
  localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [30:0] HUBER_DELTA_RESET   = 31'd65536;
  localparam logic [31:0] INVERSE_COUNT_RESET = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUBER_DELTA   = 1'b0,
    REG_INVERSE_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] prediction_0;
    logic signed [31:0] prediction_1;
    logic signed [31:0] prediction_2;
    logic signed [31:0] prediction_3;
    logic signed [31:0] target_0;
    logic signed [31:0] target_1;
    logic signed [31:0] target_2;
    logic signed [31:0] target_3;
    logic [2:0]         lanes_used;
    logic               last_group;
  } in_t;

  typedef struct packed {
    logic signed [31:0] gradient_0;
    logic signed [31:0] gradient_1;
    logic signed [31:0] gradient_2;
    logic signed [31:0] gradient_3;
    logic               loss_valid;
    logic [31:0]        mean_loss;
  } out_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic clamp;
    logic mul;
    logic term;
  } lane_ctl_t;

  typedef struct packed {
    logic                  acc;
    logic [LANE_IDX_W-1:0] sel;
    logic                  mean_mul;
    logic                  mean_fin;
  } merge_ctl_t;

endpackage

// File: sv/huber_loss_and_gradient.sv
`timescale 1ns / 1ps
// Huber loss and gradient top level: configuration registers, sequencer, lanes and result register.
// Depends on hlg_pkg, hlg_lane and hlg_merge.
//
// Each request carries up to four prediction and target pairs that four lanes process side by
// side through difference, clamp, multiply and loss-term stages, after which the merging stage
// adds the lane terms into the 64-bit accumulator one lane per cycle. When last_group is set,
// the sequencer then runs the mean multiply and round states before completion. The sequencer
// takes one request at a time; the next request is accepted while a finished result still waits
// in the output register. If the previous result has not been taken when a request completes,
// the sequencer holds in its completion state until the output register is free, which delays
// its return to idle and so the next accept.

module huber_loss_and_gradient (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [hlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  hlg_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output hlg_pkg::out_t                   out_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_CLAMP = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_TERM  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_MMUL  = 9'b001000000,
    S_MFIN  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [30:0]                    huber_delta;
  logic [31:0]                    inverse_count;
  logic [63:0]                    delta_sq_half;
  logic                           last_r;
  logic [hlg_pkg::LANE_IDX_W-1:0] lane_cnt;
  logic                           accept;
  logic                           out_free;
  logic                           acc_end;
  hlg_pkg::lane_ctl_t             lane_ctl;
  hlg_pkg::merge_ctl_t            merge_ctl;
  hlg_pkg::out_t                  out_next;
  logic signed [31:0]             pred [hlg_pkg::LANES];
  logic signed [31:0]             targ [hlg_pkg::LANES];
  logic signed [31:0]             grad [hlg_pkg::LANES];
  logic [63:0]                    terms [hlg_pkg::LANES];
  logic [31:0]                    mean;

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign acc_end  = (lane_cnt == hlg_pkg::LANE_IDX_W'(hlg_pkg::LANES - 1));

  assign pred[0] = in_data.prediction_0;
  assign pred[1] = in_data.prediction_1;
  assign pred[2] = in_data.prediction_2;
  assign pred[3] = in_data.prediction_3;
  assign targ[0] = in_data.target_0;
  assign targ[1] = in_data.target_1;
  assign targ[2] = in_data.target_2;
  assign targ[3] = in_data.target_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      huber_delta   <= hlg_pkg::HUBER_DELTA_RESET;
      inverse_count <= hlg_pkg::INVERSE_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (hlg_pkg::cfg_reg_t'(cfg_index))
        hlg_pkg::REG_HUBER_DELTA:   huber_delta   <= cfg_data[30:0];
        hlg_pkg::REG_INVERSE_COUNT: inverse_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    delta_sq_half <= (64'(huber_delta) * 64'(huber_delta)) >> 1;
  end

  always_comb begin
    lane_ctl       = '0;
    lane_ctl.load  = accept;
    lane_ctl.diff  = (state == S_DIFF);
    lane_ctl.clamp = (state == S_CLAMP);
    lane_ctl.mul   = (state == S_MUL);
    lane_ctl.term  = (state == S_TERM);
    merge_ctl          = '0;
    merge_ctl.acc      = (state == S_ACC);
    merge_ctl.sel      = lane_cnt;
    merge_ctl.mean_mul = (state == S_MMUL);
    merge_ctl.mean_fin = (state == S_MFIN);
  end

  for (genvar i = 0; i < hlg_pkg::LANES; i++) begin : g_lane
    hlg_lane u_lane (
      .clk           (clk),
      .ctl           (lane_ctl),
      .en            (in_data.lanes_used > 3'(i)),
      .prediction    (pred[i]),
      .target        (targ[i]),
      .huber_delta   (huber_delta),
      .inverse_count (inverse_count),
      .delta_sq_half (delta_sq_half),
      .gradient      (grad[i]),
      .term          (terms[i])
    );
  end

  hlg_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (merge_ctl),
    .terms         (terms),
    .inverse_count (inverse_count),
    .mean          (mean)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_DIFF;
      S_DIFF:  state_next = S_CLAMP;
      S_CLAMP: state_next = S_MUL;
      S_MUL:   state_next = S_TERM;
      S_TERM:  state_next = S_ACC;
      S_ACC:   if (acc_end) state_next = last_r ? S_MMUL : S_DONE;
      S_MMUL:  state_next = S_MFIN;
      S_MFIN:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lane_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_ACC) begin
        lane_cnt <= acc_end ? '0 : lane_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_data.last_group;
    end
  end

  always_comb begin
    out_next            = '0;
    out_next.gradient_0 = grad[0];
    out_next.gradient_1 = grad[1];
    out_next.gradient_2 = grad[2];
    out_next.gradient_3 = grad[3];
    out_next.loss_valid = last_r;
    out_next.mean_loss  = last_r ? mean : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= out_next;
    end
  end

  a_mean_only_when_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.loss_valid |-> out_data.mean_loss == 32'd0)
    else $error("mean_loss non-zero without loss_valid");

  a_one_request_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented outside the completion state");

endmodule

// File: sv/hlg_lane.sv
`timescale 1ns / 1ps
// One element lane: difference, clamp, gradient product and Huber loss term.
// Depends on hlg_pkg for the stage control struct.

module hlg_lane (
  input  logic               clk,
  input  hlg_pkg::lane_ctl_t ctl,
  input  logic               en,
  input  logic signed [31:0] prediction,
  input  logic signed [31:0] target,
  input  logic [30:0]        huber_delta,
  input  logic [31:0]        inverse_count,
  input  logic [63:0]        delta_sq_half,
  output logic signed [31:0] gradient,
  output logic [63:0]        term
);

  logic               en_r;
  logic signed [31:0] pred_r;
  logic signed [31:0] targ_r;
  logic signed [31:0] diff_r;
  logic signed [31:0] clip_r;
  logic [31:0]        abs_r;
  logic               small_r;
  logic [63:0]        sq_r;
  logic signed [32:0] diff_wide;
  logic signed [31:0] diff_sat;
  logic signed [31:0] delta_pos;
  logic signed [31:0] delta_neg;
  logic signed [31:0] clip_next;
  logic [31:0]        abs_next;
  logic signed [63:0] grad_prod;
  logic [63:0]        sq_next;

  assign diff_wide = {pred_r[31], pred_r} - {targ_r[31], targ_r};

  always_comb begin
    if (diff_wide[32] != diff_wide[31]) begin
      diff_sat = diff_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      diff_sat = diff_wide[31:0];
    end
  end

  assign delta_pos = $signed({1'b0, huber_delta});
  assign delta_neg = -delta_pos;

  always_comb begin
    priority if (diff_r > delta_pos) begin
      clip_next = delta_pos;
    end else if (diff_r < delta_neg) begin
      clip_next = delta_neg;
    end else begin
      clip_next = diff_r;
    end
  end

  assign abs_next  = diff_r[31] ? 32'(-diff_r) : 32'(diff_r);
  assign grad_prod = 64'(clip_r) * 64'($signed({1'b0, inverse_count}));
  assign sq_next   = 64'(abs_r) * 64'(small_r ? abs_r : {1'b0, huber_delta});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      en_r   <= en;
      pred_r <= prediction;
      targ_r <= target;
    end
    if (ctl.diff) begin
      diff_r <= diff_sat;
    end
    if (ctl.clamp) begin
      clip_r  <= clip_next;
      abs_r   <= abs_next;
      small_r <= (abs_next <= {1'b0, huber_delta});
    end
    if (ctl.mul) begin
      gradient <= en_r ? grad_prod[63:32] : 32'sd0;
      sq_r     <= sq_next;
    end
    if (ctl.term) begin
      if (!en_r) begin
        term <= '0;
      end else if (small_r) begin
        term <= {1'b0, sq_r[63:1]};
      end else begin
        term <= sq_r - delta_sq_half;
      end
    end
  end

endmodule

// File: sv/hlg_merge.sv
`timescale 1ns / 1ps
// Merging stage: saturating accumulation of the lane loss terms and the mean.
// Depends on hlg_pkg for the lane count and the merge control struct.

module hlg_merge (
  input  logic                clk,
  input  logic                rst,
  input  hlg_pkg::merge_ctl_t ctl,
  input  logic [63:0]         terms [hlg_pkg::LANES],
  input  logic [31:0]         inverse_count,
  output logic [31:0]         mean
);

  logic [63:0] loss_sum;
  logic [64:0] sum_wide;
  logic [63:0] hi_prod;
  logic [63:0] lo_prod;
  logic [63:0] mean_wide;
  logic [47:0] mean_q;

  assign sum_wide  = {1'b0, loss_sum} + {1'b0, terms[ctl.sel]};
  assign mean_wide = hi_prod + {32'd0, lo_prod[63:32]};
  assign mean_q    = mean_wide[63:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_sum <= '0;
    end else if (ctl.mean_fin) begin
      loss_sum <= '0;
    end else if (ctl.acc) begin
      loss_sum <= sum_wide[64] ? '1 : sum_wide[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mean_mul) begin
      hi_prod <= 64'(loss_sum[63:32]) * 64'(inverse_count);
      lo_prod <= 64'(loss_sum[31:0]) * 64'(inverse_count);
    end
    if (ctl.mean_fin) begin
      mean <= (|mean_q[47:32]) ? 32'hFFFF_FFFF : mean_q[31:0];
    end
  end

endmodule
